// File: design/hvacs_pkg.sv
// hvacs_pkg: shared types and constants of the Viterbi add-compare-select engine.
// Used by hvacs_ctrl, hvacs_dp, hvacs_chk and the top level; depends on nothing.
`timescale 1ns / 1ps

package hvacs_pkg;

    localparam int N_STATES  = 32;
    localparam int IDX_W     = $clog2(N_STATES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int SCORE_W   = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]   ACTIVE_RESET = CNT_W'(N_STATES);

    localparam logic KIND_POINTER = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [2:0] {
        FUNC_BEGIN = 3'd0,
        FUNC_INIT  = 3'd1,
        FUNC_TRANS = 3'd2,
        FUNC_CLOSE = 3'd3,
        FUNC_END   = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_UPDATE,
        S_REPORT,
        S_WALK_RD,
        S_WALK_OUT,
        S_FLIP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // take the input item
        logic clear_all;  // begin sequence
        logic add;        // form candidate score
        logic update;     // compare and write back
        logic emit_end;   // load end report into output register
        logic emit_ptr;   // load one back pointer into output register
        logic idx_clr;
        logic idx_inc;
        logic flip;       // swap score banks, clear new current bank
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_func func;
        logic  out_free;
        logic  walk_last;
    } t_stat;

endpackage

// File: design/hvacs_ctrl.sv
// hvacs_ctrl: sequencing state machine of the add-compare-select engine.
// Depends on hvacs_pkg; drives hvacs_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module hvacs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hvacs_pkg::t_stat   i_stat,
    output hvacs_pkg::t_cmd    o_cmd
);

    hvacs_pkg::t_state r_state;
    hvacs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hvacs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hvacs_pkg::S_IDLE: begin
                if (i_in_valid) n_state = hvacs_pkg::S_DISPATCH;
            end
            hvacs_pkg::S_DISPATCH: begin
                case (i_stat.func)
                    hvacs_pkg::FUNC_INIT,
                    hvacs_pkg::FUNC_TRANS,
                    hvacs_pkg::FUNC_END:   n_state = hvacs_pkg::S_ADD;
                    hvacs_pkg::FUNC_CLOSE: n_state = hvacs_pkg::S_WALK_RD;
                    default:               n_state = hvacs_pkg::S_IDLE;
                endcase
            end
            hvacs_pkg::S_ADD:    n_state = hvacs_pkg::S_UPDATE;
            hvacs_pkg::S_UPDATE: begin
                if (i_stat.func == hvacs_pkg::FUNC_END) n_state = hvacs_pkg::S_REPORT;
                else                                    n_state = hvacs_pkg::S_IDLE;
            end
            hvacs_pkg::S_REPORT: begin
                if (i_stat.out_free) n_state = hvacs_pkg::S_IDLE;
            end
            hvacs_pkg::S_WALK_RD: n_state = hvacs_pkg::S_WALK_OUT;
            hvacs_pkg::S_WALK_OUT: begin
                if (i_stat.out_free) begin
                    if (i_stat.walk_last) n_state = hvacs_pkg::S_FLIP;
                    else                  n_state = hvacs_pkg::S_WALK_RD;
                end
            end
            hvacs_pkg::S_FLIP: n_state = hvacs_pkg::S_IDLE;
            default:           n_state = hvacs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hvacs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            hvacs_pkg::S_DISPATCH: begin
                o_cmd.clear_all = (i_stat.func == hvacs_pkg::FUNC_BEGIN);
                o_cmd.idx_clr   = (i_stat.func == hvacs_pkg::FUNC_CLOSE);
            end
            hvacs_pkg::S_ADD:    o_cmd.add = 1'b1;
            hvacs_pkg::S_UPDATE: o_cmd.update = 1'b1;
            hvacs_pkg::S_REPORT: o_cmd.emit_end = i_stat.out_free;
            hvacs_pkg::S_WALK_OUT: begin
                o_cmd.emit_ptr = i_stat.out_free;
                o_cmd.idx_inc  = i_stat.out_free & ~i_stat.walk_last;
            end
            hvacs_pkg::S_FLIP: o_cmd.flip = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: design/hvacs_dp.sv
// hvacs_dp: score memory, pointer file, saturating adder, comparator and
// output register of the add-compare-select engine. Depends on hvacs_pkg.
`timescale 1ns / 1ps

module hvacs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hvacs_pkg::t_cmd                     i_cmd,
    output hvacs_pkg::t_stat                    o_stat,
    input  logic [hvacs_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [2:0]                          i_in_func,
    input  logic                                i_cfg_wr_en,
    input  logic [hvacs_pkg::CNT_W-1:0]         i_cfg_wr_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hvacs_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic                                o_out_kind,
    output logic                                o_out_last
);

    localparam int IW = hvacs_pkg::IDX_W;
    localparam int CW = hvacs_pkg::CNT_W;
    localparam int SW = hvacs_pkg::SCORE_W;
    localparam int NS = hvacs_pkg::N_STATES;

    // latched item
    hvacs_pkg::t_func r_func;
    logic [IW-1:0]    r_from;
    logic [IW-1:0]    r_to;
    logic [SW-1:0]    r_w;
    logic             r_wfin;

    logic [CW-1:0]    r_active;
    logic             r_bank;           // bank holding current scores
    logic [IW-1:0]    r_idx;

    // scores of both banks; finite flags act as valid bits
    logic [SW-1:0]    mem [2*NS];
    logic [1:0][NS-1:0] r_fin;
    logic [IW-1:0]    r_bp [NS];
    logic [NS-1:0]    r_bpv;

    logic [SW-1:0]    r_rd_a;           // current bank
    logic             r_rd_a_fin;
    logic [SW-1:0]    r_rd_b;           // previous bank
    logic             r_rd_b_fin;
    logic [IW-1:0]    r_bp_rd;
    logic             r_bpv_rd;

    logic [SW-1:0]    r_cand;
    logic             r_cand_ok;

    logic [SW-1:0]    r_best_val;
    logic             r_best_fin;
    logic [IW-1:0]    r_best_state;

    logic             r_out_valid;
    logic [hvacs_pkg::OUT_DATA_W-1:0] r_out_data;
    logic             r_out_kind;
    logic             r_out_last;

    logic [CW-1:0]    n_active_eff;
    logic [IW-1:0]    idx_a;
    logic [hvacs_pkg::ADDR_W-1:0] addr_a;
    logic [hvacs_pkg::ADDR_W-1:0] addr_b;
    logic             to_ok;
    logic             from_ok;
    logic [SW:0]      sum_wide;
    logic [SW-1:0]    sum_sat;
    logic [SW-1:0]    tgt_val;
    logic             tgt_fin;
    logic             better;
    logic             do_write;
    logic             out_free;

    always_comb begin
        if (r_active == '0)                        n_active_eff = CW'(1);
        else if (r_active > CW'(NS))               n_active_eff = CW'(NS);
        else                                       n_active_eff = r_active;
    end

    assign to_ok   = {1'b0, r_to}   < n_active_eff;
    assign from_ok = {1'b0, r_from} < n_active_eff;

    assign idx_a  = (r_func == hvacs_pkg::FUNC_CLOSE) ? r_idx : r_to;
    assign addr_a = {r_bank, idx_a};
    assign addr_b = {~r_bank, r_from};

    assign sum_wide = {r_rd_b[SW-1], r_rd_b} + {r_w[SW-1], r_w};
    always_comb begin
        if (sum_wide[SW] != sum_wide[SW-1])
            sum_sat = sum_wide[SW] ? hvacs_pkg::SCORE_MIN : hvacs_pkg::SCORE_MAX;
        else
            sum_sat = sum_wide[SW-1:0];
    end

    assign tgt_val  = (r_func == hvacs_pkg::FUNC_END) ? r_best_val : r_rd_a;
    assign tgt_fin  = (r_func == hvacs_pkg::FUNC_END) ? r_best_fin : r_rd_a_fin;
    assign better   = !tgt_fin || ($signed(r_cand) > $signed(tgt_val));
    assign do_write = i_cmd.update && r_cand_ok && better &&
                      (r_func != hvacs_pkg::FUNC_END);

    assign out_free = !r_out_valid || i_out_ready;

    // score memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (do_write) mem[{r_bank, r_to}] <= r_cand;
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= hvacs_pkg::t_func'(i_in_func);
            r_from <= i_in_data[IW-1:0];
            r_to   <= i_in_data[2*IW-1:IW];
            r_w    <= i_in_data[2*IW+SW-1:2*IW];
            r_wfin <= i_in_data[2*IW+SW];
        end
        r_rd_a_fin <= r_fin[r_bank][idx_a];
        r_rd_b_fin <= r_fin[~r_bank][r_from];
        r_bp_rd    <= r_bp[r_idx];
        r_bpv_rd   <= r_bpv[r_idx];
        if (i_cmd.add) begin
            case (r_func)
                hvacs_pkg::FUNC_INIT: begin
                    r_cand    <= r_w;
                    r_cand_ok <= to_ok && r_wfin;
                end
                hvacs_pkg::FUNC_TRANS: begin
                    r_cand    <= sum_sat;
                    r_cand_ok <= to_ok && from_ok && r_wfin && r_rd_b_fin;
                end
                hvacs_pkg::FUNC_END: begin
                    r_cand    <= sum_sat;
                    r_cand_ok <= from_ok && r_wfin && r_rd_b_fin;
                end
                default: begin
                    r_cand    <= r_w;
                    r_cand_ok <= 1'b0;
                end
            endcase
        end
        if (do_write && r_func == hvacs_pkg::FUNC_TRANS) r_bp[r_to] <= r_from;
        if (i_cmd.update && r_cand_ok && better && r_func == hvacs_pkg::FUNC_END) begin
            r_best_val   <= r_cand;
            r_best_state <= r_from;
        end
        if (i_cmd.emit_ptr) begin
            r_out_kind <= hvacs_pkg::KIND_POINTER;
            r_out_last <= o_stat.walk_last;
            r_out_data <= {4'd0, r_rd_a_fin, (r_rd_a_fin ? r_rd_a : {SW{1'b0}}),
                           r_bpv_rd, (r_bpv_rd ? r_bp_rd : {IW{1'b0}}), r_idx};
        end else if (i_cmd.emit_end) begin
            r_out_kind <= hvacs_pkg::KIND_END;
            r_out_last <= 1'b1;
            r_out_data <= {4'd0, r_best_fin, (r_best_fin ? r_best_val : {SW{1'b0}}),
                           r_best_fin, (r_best_fin ? r_best_state : {IW{1'b0}}),
                           (r_best_fin ? r_best_state : {IW{1'b0}})};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= hvacs_pkg::ACTIVE_RESET;
            r_bank      <= 1'b0;
            r_fin       <= '0;
            r_bpv       <= '0;
            r_best_fin  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_active <= i_cfg_wr_data;
            if (i_cmd.clear_all) begin
                r_fin      <= '0;
                r_bpv      <= '0;
                r_best_fin <= 1'b0;
            end
            if (do_write) begin
                r_fin[r_bank][r_to] <= 1'b1;
                if (r_func == hvacs_pkg::FUNC_TRANS) r_bpv[r_to] <= 1'b1;
            end
            if (i_cmd.update && r_cand_ok && better && r_func == hvacs_pkg::FUNC_END)
                r_best_fin <= 1'b1;
            // old previous bank becomes the cleared current bank
            if (i_cmd.flip) begin
                r_bank         <= ~r_bank;
                r_fin[~r_bank] <= '0;
                r_bpv          <= '0;
            end
            if (i_cmd.idx_clr)      r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + IW'(1);
            if (i_cmd.emit_ptr || i_cmd.emit_end) r_out_valid <= 1'b1;
            else if (i_out_ready)                 r_out_valid <= 1'b0;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.out_free  = out_free;
    assign o_stat.walk_last = ({1'b0, r_idx} == (n_active_eff - CW'(1)));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

// File: design/hmm_viterbi_add_compare_select.sv
// Log-domain Viterbi add-compare-select engine for a hidden Markov model.
//
// Input stream (s_axis): one arc item per transfer; tuser carries the function
// code, tdata the state indices, the Q16.16 weight and its finite flag.
// Output stream (m_axis): back pointer items (tuser 0) and end reports (tuser 1);
// tlast marks the final item caused by one input item. Config: i_cfg_wr_en /
// i_cfg_wr_data set the active state count; user: only while idle (unenforced).
//
// Timing: one item is handled at a time; s_axis_tready is high only when idle.
//   begin or unknown code: accept, then dispatch.  initial / transition arc:
//   accept, memory read, saturating add, compare and write.
//   end arc: the same steps, then the report is loaded once the output is free.
//   close: per active state a memory read and an output load, then a bank flip.
// Reset (synchronous, active low): all scores minus infinity, no pointers,
// no best end, active count 32, output empty.
// A stalled receiver holds the output register; the walk waits on it.
`timescale 1ns / 1ps

module hmm_viterbi_add_compare_select (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [4:0] from_state, [9:5] to_state, [41:10] arc_weight, [42] weight_finite
    input  logic [hvacs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] func
    input  logic [2:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [4:0] state_index, [9:5] back_pointer, [10] pointer_valid,
    // [42:11] score, [43] score_finite
    output logic [hvacs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] result_kind
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_wr_en,
    input  logic [hvacs_pkg::CNT_W-1:0]         i_cfg_wr_data
);

    hvacs_pkg::t_cmd  cmd;
    hvacs_pkg::t_stat stat;

    hvacs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hvacs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_data     (s_axis_tdata),
        .i_in_func     (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_kind    (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

endmodule

// File: design/hvacs_chk.sv
// hvacs_chk: port-level checks of the add-compare-select engine, bound to the
// top level. Depends on hvacs_pkg for widths.
`timescale 1ns / 1ps

module hvacs_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [hvacs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tlast
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // end report is always a single item with matching state fields
    a_end_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[4:0] == m_axis_tdata[9:5]) &&
            (m_axis_tdata[10] == m_axis_tdata[43]))
        else $error("malformed end report");

    // minus infinity scores show as zero
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[43] |-> m_axis_tdata[42:11] == '0)
        else $error("non-finite score not zero");

    // no new item is taken while a pointer walk is still emitting
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser && !m_axis_tlast |->
            !(s_axis_tvalid && s_axis_tready))
        else $error("input accepted during pointer walk");

endmodule

bind hmm_viterbi_add_compare_select hvacs_chk u_hvacs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
